### src/neighbor_cache_4way_lru_aging_macros.svh
// ----------------------------------------------------------------------------
// Neighbour cache assertion macros
// Shared concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_CACHE_4WAY_LRU_AGING_MACROS_SVH
`define NEIGHBOR_CACHE_4WAY_LRU_AGING_MACROS_SVH
`ifndef SYNTHESIS
`define NC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define NC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### src/nc4_pkg.sv
// ----------------------------------------------------------------------------
// Neighbour cache package
// Command codes, register indexes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none
package nc4_pkg;
   localparam int WAYS = 4;
   typedef enum logic [1:0] {
      CMD_QUERY  = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_AGE    = 2'd3
   } cmd_type;
   typedef enum logic [1:0] {
      REG_UNICAST_AFTER   = 2'd0,
      REG_UNICAST_END     = 2'd1,
      REG_BROADCAST_AFTER = 2'd2,
      REG_TIME_TO_LIVE    = 2'd3
   } reg_type;
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_EVAL  = 2'd1,
      ST_EMIT  = 2'd2,
      ST_CLEAR = 2'd3
   } state_type;
   localparam logic [15:0] RST_UNICAST_AFTER   = 16'd60;
   localparam logic [15:0] RST_UNICAST_END     = 16'd90;
   localparam logic [15:0] RST_BROADCAST_AFTER = 16'd120;
   localparam logic [15:0] RST_TIME_TO_LIVE    = 16'd180;
endpackage
`default_nettype wire

### src/neighbor_cache_4way_lru_aging.sv
// ----------------------------------------------------------------------------
// Neighbour cache, 4-way set associative with aging
// Maps 128-bit addresses to MACs; query, update, remove and row aging.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  req_    | in        | start / busy
//  rsp_    | out       | rsp_strobe, one cycle, no back-pressure
//  csr_    | in        | csr_valid / csr_ready
// A command reads its row when accepted, then decides and writes back in ST_EVAL;
// query, update and remove respond there, age_row with results goes on to ST_EMIT.
// After reset a clearing pass sweeps every row of the valid memory, busy high.
// The row memory port does one read, one write per cycle; busy blocks new commands.
`default_nettype none
module neighbor_cache_4way_lru_aging #(
   parameter int ROWS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire nc4_pkg::cmd_type      req_command,
   input  wire logic [9:0]            req_row,
   input  wire logic [63:0]           req_addr_low,
   input  wire logic [63:0]           req_addr_high,
   input  wire logic [47:0]           req_mac_in,
   input  wire logic                  req_touch,
   input  wire logic                  req_upsert,
   input  wire logic [15:0]           req_now_time,
   output logic                       rsp_strobe,
   output logic                       rsp_found,
   output logic [1:0]                 rsp_hit_way,
   output logic [47:0]                rsp_mac_out,
   output logic                       rsp_request_valid,
   output logic                       rsp_request_unicast,
   output logic [63:0]                rsp_request_addr_low,
   output logic [63:0]                rsp_request_addr_high,
   output logic [47:0]                rsp_request_mac,
   output logic                       rsp_last,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_data
);
   import nc4_pkg::*;
   `include "neighbor_cache_4way_lru_aging_macros.svh"

   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int EW = 64 + 64 + 48 + 16;
   localparam int ROW_SHIFT = 21;
   localparam int ROW_RECIP = ((1 << ROW_SHIFT) + ROWS - 1) / ROWS;

   logic [WAYS-1:0]    vmem [ROWS];
   logic [WAYS*EW-1:0] emem [ROWS];

   state_type state_ff, state_in;
   logic [RW-1:0]  clr_ff, clr_in;
   logic [15:0]    ua_ff, ue_ff, ba_ff, ttl_ff;
   cmd_type        cmd_ff;
   logic [RW-1:0]  row_ff;
   logic [63:0]    lo_ff, hi_ff;
   logic [47:0]    mac_ff;
   logic           touch_ff, ups_ff;
   logic [15:0]    now_ff;
   logic [WAYS-1:0] vrd_ff;
   logic [WAYS*EW-1:0] erow_ff;
   logic [WAYS-1:0] pend_ff, pend_in;
   logic [WAYS-1:0] uni_ff, uni_in;
   logic [EW-1:0]   ent_ff [WAYS];

   logic accept;
   logic [RW-1:0] req_r;
   assign accept = start & ~busy;

   if (ROWS >= 1024) begin : g_row_direct
      assign req_r = RW'(req_row);
   end else begin : g_row_mod
      logic [31:0] row_prod;
      logic [9:0]  row_quot;
      logic [19:0] row_back;
      assign row_prod = 32'(req_row) * 32'(ROW_RECIP);
      assign row_quot = row_prod[ROW_SHIFT+9:ROW_SHIFT];
      assign row_back = 20'(row_quot) * 20'(ROWS);
      assign req_r = RW'(req_row - row_back[9:0]);
   end

   // read
   always_ff @(posedge clock) begin
      if (accept) begin
         vrd_ff <= vmem[req_r];
         erow_ff <= emem[req_r];
         cmd_ff <= req_command; row_ff <= req_r; lo_ff <= req_addr_low;
         hi_ff <= req_addr_high; mac_ff <= req_mac_in; touch_ff <= req_touch;
         ups_ff <= req_upsert; now_ff <= req_now_time;
      end
   end

   logic [EW-1:0] erd [WAYS];
   always_comb begin
      for (int w = 0; w < WAYS; w++) erd[w] = erow_ff[w*EW +: EW];
   end

   // evaluate
   logic [WAYS-1:0] match, bcast, unic, expd;
   logic [1:0] mway, iway, lway, wway;
   logic any_m, any_i, do_wr, do_ewr;
   logic [15:0] best;
   logic [WAYS-1:0] vnew;
   logic [EW-1:0] ewd;
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         logic [15:0] age;
         age = now_ff - erd[w][15:0];
         match[w] = vrd_ff[w] && erd[w][EW-1 -: 64] == hi_ff
                    && erd[w][EW-65 -: 64] == lo_ff;
         expd[w]  = vrd_ff[w] && age > ttl_ff;
         bcast[w] = vrd_ff[w] && !expd[w] && age > ba_ff;
         unic[w]  = vrd_ff[w] && !expd[w] && !bcast[w] && age <= ue_ff && age > ua_ff;
      end
      any_m = |match; any_i = ~&vrd_ff;
      mway = match[0] ? 2'd0 : match[1] ? 2'd1 : match[2] ? 2'd2 : 2'd3;
      iway = !vrd_ff[0] ? 2'd0 : !vrd_ff[1] ? 2'd1 : !vrd_ff[2] ? 2'd2 : 2'd3;
      best = erd[0][15:0]; lway = 2'd0;
      for (int w = 1; w < WAYS; w++)
         if (erd[w][15:0] < best) begin best = erd[w][15:0]; lway = 2'(w); end
      wway = any_m ? mway : any_i ? iway : lway;
      vnew = vrd_ff; do_wr = 1'b0; do_ewr = 1'b0;
      ewd = erd[mway];
      case (cmd_ff)
         CMD_QUERY: begin
            do_ewr = any_m & touch_ff;
            ewd = {erd[mway][EW-1:16], now_ff};
         end
         CMD_UPDATE: begin
            do_ewr = any_m | ups_ff; do_wr = do_ewr;
            vnew = vrd_ff | (WAYS'(1) << wway);
            ewd = {hi_ff, lo_ff, mac_ff, now_ff};
         end
         CMD_REMOVE: begin do_wr = 1'b1; vnew = vrd_ff & ~match; end
         CMD_AGE:    begin do_wr = 1'b1; vnew = vrd_ff & ~expd; end
         default: ;
      endcase
   end
   logic [1:0] ewway;
   assign ewway = (cmd_ff == CMD_UPDATE) ? wway : mway;

   logic [WAYS*EW-1:0] ewrow;
   always_comb begin
      ewrow = erow_ff;
      ewrow[ewway*EW +: EW] = ewd;
   end

   // write back
   logic clearing;
   assign clearing = state_ff == ST_CLEAR;
   always_ff @(posedge clock) begin
      if (clearing) vmem[clr_ff] <= '0;
      else if (state_ff == ST_EVAL && do_wr) vmem[row_ff] <= vnew;
      if (state_ff == ST_EVAL && do_ewr) emem[row_ff] <= ewrow;
   end

   // aging emission
   logic [1:0] pway;
   assign pway = pend_ff[0] ? 2'd0 : pend_ff[1] ? 2'd1 : pend_ff[2] ? 2'd2 : 2'd3;
   always_ff @(posedge clock) begin
      if (state_ff == ST_EVAL)
         for (int w = 0; w < WAYS; w++) ent_ff[w] <= erd[w];
      pend_ff <= pend_in; uni_ff <= uni_in;
   end

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; pend_in = pend_ff; uni_in = uni_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + RW'(1);
            if (clr_ff == RW'(ROWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (accept) state_in = ST_EVAL;
         ST_EVAL: begin
            pend_in = bcast | unic; uni_in = unic;
            if (cmd_ff == CMD_AGE && |(bcast | unic)) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_EMIT: begin
            pend_in = pend_ff & ~(WAYS'(1) << pway);
            if ($countones(pend_ff) == 1) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0;
         ua_ff <= RST_UNICAST_AFTER; ue_ff <= RST_UNICAST_END;
         ba_ff <= RST_BROADCAST_AFTER; ttl_ff <= RST_TIME_TO_LIVE;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in;
         if (csr_valid) begin
            case (reg_type'(csr_index))
               REG_UNICAST_AFTER:   ua_ff <= csr_data;
               REG_UNICAST_END:     ue_ff <= csr_data;
               REG_BROADCAST_AFTER: ba_ff <= csr_data;
               REG_TIME_TO_LIVE:    ttl_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign csr_ready = 1'b1;
   assign busy = state_ff != ST_IDLE;

   // outputs
   always_comb begin
      rsp_strobe = 1'b0; rsp_found = 1'b0; rsp_hit_way = '0; rsp_mac_out = '0;
      rsp_request_valid = 1'b0; rsp_request_unicast = 1'b0;
      rsp_request_addr_low = '0; rsp_request_addr_high = '0; rsp_request_mac = '0;
      rsp_last = 1'b0;
      case (state_ff)
         ST_EVAL: begin
            if (!(cmd_ff == CMD_AGE && |(bcast | unic))) begin
               rsp_strobe = 1'b1; rsp_last = 1'b1;
               if (cmd_ff == CMD_QUERY && any_m) begin
                  rsp_found = 1'b1; rsp_hit_way = mway;
                  rsp_mac_out = erd[mway][63:16];
               end
               if (cmd_ff == CMD_UPDATE) begin
                  rsp_found = any_m;
                  rsp_hit_way = (any_m | ups_ff) ? wway : 2'd0;
               end
            end
         end
         ST_EMIT: begin
            rsp_strobe = 1'b1; rsp_request_valid = 1'b1;
            rsp_request_unicast = uni_ff[pway];
            rsp_request_addr_high = ent_ff[pway][EW-1 -: 64];
            rsp_request_addr_low = ent_ff[pway][EW-65 -: 64];
            rsp_request_mac = uni_ff[pway] ? ent_ff[pway][63:16] : 48'd0;
            rsp_last = $countones(pend_ff) == 1;
         end
         default: ;
      endcase
   end

   `NC_ASSERT_IMPL(a_busy_no_accept, clock, reset, state_ff != ST_IDLE, !accept, "accept while busy")
   `NC_ASSERT_NEXT(a_accept_eval, clock, reset, accept, state_ff == ST_EVAL, "no eval after accept")
   `NC_ASSERT_IMPL(a_emit_pending, clock, reset, state_ff == ST_EMIT, pend_ff != '0, "emit with nothing pending")
   `NC_ASSERT_IMPL(a_last_strobe, clock, reset, rsp_last, rsp_strobe, "last without strobe")
endmodule
`default_nettype wire

### test/tb_neighbor_cache_4way_lru_aging.sv
// ----------------------------------------------------------------------------
// Neighbour cache testbench
// Drives query, update, remove and row-aging requests through the start/busy
// port and checks every response strobe against an in-bench cache predictor.
// It covers several threshold settings, the extreme ones among them, and
// random gaps on the request side.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
   nc4_pkg::cmd_type command;
   logic [9:0]       row;
   logic [63:0]      addr_low;
   logic [63:0]      addr_high;
   logic [47:0]      mac_in;
   logic             touch;
   logic             upsert;
   logic [15:0]      now_time;
} cache_request_type;

typedef struct {
   logic        found;
   logic [1:0]  hit_way;
   logic [47:0] mac_out;
   logic        request_valid;
   logic        request_unicast;
   logic [63:0] request_addr_low;
   logic [63:0] request_addr_high;
   logic [47:0] request_mac;
   logic        last;
} cache_response_type;

class cache_scoreboard;
   logic [15:0]     unicast_after, unicast_end, broadcast_after, time_to_live;
   logic [3:0]      valid_bits [1024];
   logic [63:0]     tag_low [4096];
   logic [63:0]     tag_high [4096];
   logic [47:0]     mac_store [4096];
   logic [15:0]     access_time [4096];
   cache_response_type pending_responses [$];
   int              errors;
   int              responses;
   int              refresh_requests;

   function new();
      unicast_after   = nc4_pkg::RST_UNICAST_AFTER;
      unicast_end     = nc4_pkg::RST_UNICAST_END;
      broadcast_after = nc4_pkg::RST_BROADCAST_AFTER;
      time_to_live    = nc4_pkg::RST_TIME_TO_LIVE;
      foreach (valid_bits[i]) valid_bits[i] = '0;
      errors = 0;
      responses = 0;
      refresh_requests = 0;
   endfunction

   function void write_register(nc4_pkg::reg_type index, logic [15:0] data);
      case (index)
         nc4_pkg::REG_UNICAST_AFTER:   unicast_after = data;
         nc4_pkg::REG_UNICAST_END:     unicast_end = data;
         nc4_pkg::REG_BROADCAST_AFTER: broadcast_after = data;
         default:                      time_to_live = data;
      endcase
   endfunction

   function logic [3:0] matching_ways(int r, logic [63:0] lo, logic [63:0] hi);
      logic [3:0] m;
      m = '0;
      for (int w = 0; w < 4; w++)
         if (valid_bits[r][w] && tag_low[r*4+w] == lo && tag_high[r*4+w] == hi) m[w] = 1'b1;
      return m;
   endfunction

   function int lowest_way(logic [3:0] m);
      for (int w = 0; w < 4; w++) if (m[w]) return w;
      return -1;
   endfunction

   function void note_request(cache_request_type q);
      cache_response_type rsp, zero_rsp;
      logic [3:0]      m, expired;
      logic [15:0]     age, best;
      int              r, way, e, n;
      zero_rsp = '{default: '0};
      rsp = zero_rsp;
      rsp.last = 1'b1;
      r = int'(q.row);
      case (q.command)
         nc4_pkg::CMD_QUERY: begin
            way = lowest_way(matching_ways(r, q.addr_low, q.addr_high));
            if (way >= 0) begin
               e = r*4 + way;
               rsp.found = 1'b1;
               rsp.hit_way = 2'(way);
               rsp.mac_out = mac_store[e];
               if (q.touch) access_time[e] = q.now_time;
            end
            pending_responses.push_back(rsp);
         end
         nc4_pkg::CMD_UPDATE: begin
            m = matching_ways(r, q.addr_low, q.addr_high);
            way = lowest_way(m);
            if (way >= 0 || q.upsert) begin
               if (way < 0) way = lowest_way(~valid_bits[r]);
               if (way < 0) begin
                  way = 0;
                  best = access_time[r*4];
                  for (int w = 1; w < 4; w++)
                     if (access_time[r*4+w] < best) begin
                        best = access_time[r*4+w];
                        way = w;
                     end
               end
               e = r*4 + way;
               valid_bits[r][way] = 1'b1;
               tag_low[e] = q.addr_low;
               tag_high[e] = q.addr_high;
               mac_store[e] = q.mac_in;
               access_time[e] = q.now_time;
               rsp.found = (m != 0);
               rsp.hit_way = 2'(way);
            end
            pending_responses.push_back(rsp);
         end
         nc4_pkg::CMD_REMOVE: begin
            valid_bits[r] &= ~matching_ways(r, q.addr_low, q.addr_high);
            pending_responses.push_back(rsp);
         end
         default: begin
            n = 0;
            expired = '0;
            for (int w = 0; w < 4; w++) begin
               e = r*4 + w;
               if (!valid_bits[r][w]) continue;
               age = q.now_time - access_time[e];
               rsp = zero_rsp;
               if (age > time_to_live) begin
                  expired[w] = 1'b1;
                  continue;
               end else if (age > broadcast_after) begin
                  rsp.request_valid = 1'b1;
               end else if (age > unicast_end) begin
                  continue;
               end else if (age > unicast_after) begin
                  rsp.request_valid = 1'b1;
                  rsp.request_unicast = 1'b1;
                  rsp.request_mac = mac_store[e];
               end else begin
                  continue;
               end
               rsp.request_addr_low = tag_low[e];
               rsp.request_addr_high = tag_high[e];
               pending_responses.push_back(rsp);
               n++;
            end
            valid_bits[r] &= ~expired;
            if (n == 0) begin
               rsp = zero_rsp;
               rsp.last = 1'b1;
               pending_responses.push_back(rsp);
            end else begin
               pending_responses[$].last = 1'b1;
            end
            refresh_requests += n;
         end
      endcase
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endfunction

   function void check_response(cache_response_type got);
      cache_response_type want;
      responses++;
      if (pending_responses.size() == 0) begin
         errors++;
         $display("%0t: unexpected response, expected none actual found=%b last=%b",
                  $time, got.found, got.last);
         return;
      end
      want = pending_responses.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("hit_way", want.hit_way, got.hit_way);
      compare_field("mac_out", want.mac_out, got.mac_out);
      compare_field("request_valid", want.request_valid, got.request_valid);
      compare_field("request_unicast", want.request_unicast, got.request_unicast);
      compare_field("request_addr_low", want.request_addr_low, got.request_addr_low);
      compare_field("request_addr_high", want.request_addr_high, got.request_addr_high);
      compare_field("request_mac", want.request_mac, got.request_mac);
      compare_field("last", want.last, got.last);
   endfunction
endclass

module tb_neighbor_cache_4way_lru_aging;
   timeunit 1ns;
   timeprecision 1ps;
   import nc4_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   cmd_type     req_command = CMD_QUERY;
   logic [9:0]  req_row = '0;
   logic [63:0] req_addr_low = '0;
   logic [63:0] req_addr_high = '0;
   logic [47:0] req_mac_in = '0;
   logic        req_touch = 1'b0;
   logic        req_upsert = 1'b0;
   logic [15:0] req_now_time = '0;
   logic        rsp_strobe, rsp_found, rsp_request_valid, rsp_request_unicast, rsp_last;
   logic [1:0]  rsp_hit_way;
   logic [47:0] rsp_mac_out, rsp_request_mac;
   logic [63:0] rsp_request_addr_low, rsp_request_addr_high;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   cache_scoreboard sb = new();
   int          cycles = 0;
   int          gap_percent = 0;
   int          requests_sent = 0;
   logic [15:0] now_clock = 16'd100;
   logic [63:0] pool_low [16];
   logic [63:0] pool_high [16];
   logic [9:0]  hot_rows [4];

   neighbor_cache_4way_lru_aging u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_row(req_row), .req_addr_low(req_addr_low),
      .req_addr_high(req_addr_high), .req_mac_in(req_mac_in), .req_touch(req_touch),
      .req_upsert(req_upsert), .req_now_time(req_now_time),
      .rsp_strobe(rsp_strobe), .rsp_found(rsp_found), .rsp_hit_way(rsp_hit_way),
      .rsp_mac_out(rsp_mac_out), .rsp_request_valid(rsp_request_valid),
      .rsp_request_unicast(rsp_request_unicast),
      .rsp_request_addr_low(rsp_request_addr_low),
      .rsp_request_addr_high(rsp_request_addr_high),
      .rsp_request_mac(rsp_request_mac), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_request('{req_command, req_row, req_addr_low, req_addr_high, req_mac_in,
                           req_touch, req_upsert, req_now_time});
      if (!reset && rsp_strobe)
         sb.check_response('{rsp_found, rsp_hit_way, rsp_mac_out, rsp_request_valid,
                             rsp_request_unicast, rsp_request_addr_low,
                             rsp_request_addr_high, rsp_request_mac, rsp_last});
   end

   task automatic send(cmd_type c, logic [9:0] r, logic [63:0] lo, logic [63:0] hi,
                       logic [47:0] mac, logic t, logic u, logic [15:0] now);
      req_command <= c;
      req_row <= r;
      req_addr_low <= lo;
      req_addr_high <= hi;
      req_mac_in <= mac;
      req_touch <= t;
      req_upsert <= u;
      req_now_time <= now;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      requests_sent++;
      if ($urandom_range(99) < gap_percent) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_percent);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(reg_type idx, logic [15:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic set_thresholds(logic [15:0] ua, logic [15:0] ue, logic [15:0] ba,
                                 logic [15:0] ttl);
      drain();
      write_reg(REG_UNICAST_AFTER, ua);
      write_reg(REG_UNICAST_END, ue);
      write_reg(REG_BROADCAST_AFTER, ba);
      write_reg(REG_TIME_TO_LIVE, ttl);
   endtask

   task automatic random_request();
      int          pick, k;
      cmd_type     c;
      logic [9:0]  r;
      logic [63:0] lo, hi;
      pick = $urandom_range(99);
      c = pick < 30 ? CMD_QUERY : pick < 65 ? CMD_UPDATE : pick < 75 ? CMD_REMOVE : CMD_AGE;
      r = $urandom_range(99) < 85 ? hot_rows[$urandom_range(3)] : 10'($urandom);
      k = $urandom_range(15);
      lo = pool_low[k];
      hi = pool_high[k];
      if ($urandom_range(99) < 10) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
      end
      now_clock += 16'($urandom_range(30));
      if ($urandom_range(99) < 3) now_clock = 16'($urandom);
      send(c, r, lo, hi, {16'($urandom), 32'($urandom)}, 1'($urandom_range(1)),
           $urandom_range(99) < 75, now_clock);
   endtask

   initial begin
      pool_low[0] = '0;
      pool_high[0] = '0;
      pool_low[1] = '1;
      pool_high[1] = '1;
      for (int i = 2; i < 16; i++) begin
         pool_low[i] = {$urandom, $urandom};
         pool_high[i] = (i < 6) ? pool_high[0] : {$urandom, $urandom};
      end
      hot_rows[0] = 10'd0;
      hot_rows[1] = 10'd1023;
      hot_rows[2] = 10'($urandom);
      hot_rows[3] = 10'($urandom);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send(CMD_QUERY, 10'd3, pool_low[0], pool_high[0], '0, 1'b1, 1'b0, 16'd1000);
      send(CMD_UPDATE, 10'd3, pool_low[0], pool_high[0], '1, 1'b0, 1'b0, 16'd1000);
      send(CMD_AGE, 10'd3, '0, '0, '0, 1'b0, 1'b0, 16'd1000);
      send(CMD_UPDATE, 10'd7, pool_low[0], pool_high[0], '0, 1'b0, 1'b1, 16'd1000);
      send(CMD_UPDATE, 10'd7, pool_low[1], pool_high[1], '1, 1'b0, 1'b1, 16'd1075);
      send(CMD_UPDATE, 10'd7, pool_low[2], pool_high[2], 48'h123456789abc, 1'b0, 1'b1,
           16'd1105);
      send(CMD_UPDATE, 10'd7, pool_low[3], pool_high[3], 48'hfedcba987654, 1'b0, 1'b1,
           16'd1130);
      send(CMD_UPDATE, 10'd7, pool_low[1], pool_high[1], '1, 1'b0, 1'b0, 16'd1075);
      send(CMD_QUERY, 10'd7, pool_low[3], pool_high[3], '0, 1'b0, 1'b0, 16'd1190);
      send(CMD_QUERY, 10'd7, pool_low[2], pool_high[2], '0, 1'b0, 1'b0, 16'd1190);
      send(CMD_AGE, 10'd7, '0, '0, '0, 1'b0, 1'b0, 16'd1200);
      send(CMD_QUERY, 10'd7, pool_low[0], pool_high[0], '0, 1'b1, 1'b0, 16'd1200);
      send(CMD_UPDATE, 10'd7, pool_low[4], pool_high[4], 48'h1, 1'b0, 1'b1, 16'd1201);
      send(CMD_UPDATE, 10'd7, pool_low[5], pool_high[5], 48'h2, 1'b0, 1'b1, 16'd1202);
      send(CMD_QUERY, 10'd7, pool_low[2], pool_high[2], '0, 1'b1, 1'b0, 16'd1210);
      send(CMD_REMOVE, 10'd7, pool_low[3], pool_high[3], '0, 1'b0, 1'b0, 16'd1210);
      send(CMD_REMOVE, 10'd7, pool_low[9], pool_high[9], '0, 1'b0, 1'b0, 16'd1210);
      send(CMD_UPDATE, 10'd1023, pool_low[1], pool_high[1], '1, 1'b0, 1'b1, 16'hfffa);
      send(CMD_AGE, 10'd1023, '0, '0, '0, 1'b0, 1'b0, 16'd40);
      send(CMD_QUERY, 10'd1023, pool_low[1], pool_high[1], '0, 1'b1, 1'b0, 16'hffff);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_thresholds(16'd60, 16'd90, 16'd120, 16'd180);
            1: set_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
            2: set_thresholds(16'hffff, 16'hffff, 16'hffff, 16'hffff);
            3: set_thresholds(16'd30, 16'd10, 16'd50, 16'd40);
            default: set_thresholds(16'd15, 16'd40, 16'd70, 16'd110);
         endcase
         for (int i = 0; i < 82; i++) begin
            gap_percent = (phase * 82 + i < 137) ? 37 : (phase * 82 + i < 274) ? 51 : 0;
            random_request();
         end
      end
      drain();
      repeat (10) @(posedge clock);

      $display("%0d requests, %0d responses, %0d refresh requests, 5 threshold settings",
               requests_sent, sb.responses, sb.refresh_requests);
      if (sb.errors == 0 && sb.pending_responses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.errors,
                  sb.pending_responses.size());
         $display("simulation failed");
      end
      $finish;
   end
endmodule

`default_nettype wire
